/* src/pvsa_pkg.sv */
// Shared types, constants and fixed-point helpers of the polynomial value/slope/area unit.
package pvsa_pkg;

	// Data widths and store depth
	localparam int DATA_W        = 32;
	localparam int MAX_TERMS_DEF = 16;

	// Command codes
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_EVAL = 1'b1;

	// Register word index on the APB port (paddr[2])
	localparam logic REG_IDX_DEGREE = 1'b0;

	// Divider: quotient bits resolved per cycle and the number of cycles
	localparam int DIV_DIGIT = 8;
	localparam int DIV_STEPS = DATA_W / DIV_DIGIT;
	localparam int DIV_CW    = $clog2(DIV_STEPS);

	// Saturation limits
	localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
	localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

	typedef struct packed {
		logic               opcode;
		logic [3:0]         coef_index;
		logic signed [31:0] value;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] poly_value;
		logic signed [31:0] slope_value;
		logic signed [31:0] area_value;
		logic               overflow;
	} result_t;

	typedef struct packed {
		logic signed [31:0] val;
		logic               ovf;
	} sat_t;

	// Clamp a wide value to 32 bits, flag when clamped
	function automatic sat_t sat32(input logic signed [63:0] v);
		sat_t r;
		if (v > SAT_MAX) begin
			r.val = 32'sh7FFF_FFFF;
			r.ovf = 1'b1;
		end else if (v < SAT_MIN) begin
			r.val = 32'sh8000_0000;
			r.ovf = 1'b1;
		end else begin
			r.val = v[31:0];
			r.ovf = 1'b0;
		end
		return r;
	endfunction

	// One Horner step: floor(acc*x / 2^16) + coef, saturated
	function automatic sat_t horner_step(input logic signed [63:0] prod,
					     input logic signed [31:0] coef);
		logic signed [63:0] sum;
		sum = (prod >>> 16) + 64'(coef);
		return sat32(sum);
	endfunction

endpackage

/* src/polynomial_value_slope_area.sv */
// Top level: coefficient store, APB register, sequencer for the three Horner passes.
//
//  channel  | handshake           | payload
//  ---------+---------------------+-----------------------------------------------
//  command  | start / busy        | cmd: opcode, coef_index, value
//  result   | done (1-cycle strobe)| result: poly_value, slope_value, area_value, overflow
//  config   | APB psel/penable    | degree at byte address 0
//
//  A load leaves busy low. An evaluate keeps busy high while it walks the
//  coefficients from d down to zero, d = degree clamped to MAX_TERMS-1: each
//  coefficient needs four issues on the one shared multiplier plus the tail of the
//  digit divider that forms the area coefficient. done is high in the cycle after the last busy cycle.
//  Reset clears the store (valid bits), degree and the sequencer at once.
//  The result receiver cannot stall; a result is shown for one cycle only.
module polynomial_value_slope_area #(
	parameter int MAX_TERMS = pvsa_pkg::MAX_TERMS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [2:0]             paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready,
	input  logic                   start,
	output logic                   busy,
	input  pvsa_pkg::cmd_t         cmd,
	output logic                   done,
	output pvsa_pkg::result_t      result
);
	import pvsa_pkg::*;

	localparam int AW  = $clog2(MAX_TERMS);
	localparam int DVW = AW + 1;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_LD   = 3'd1;
	localparam logic [2:0] S_MP   = 3'd2;
	localparam logic [2:0] S_MS   = 3'd3;
	localparam logic [2:0] S_MA   = 3'd4;
	localparam logic [2:0] S_AREA = 3'd5;
	localparam logic [2:0] S_FIN1 = 3'd6;
	localparam logic [2:0] S_FIN2 = 3'd7;

	logic [2:0]           state_q;
	logic [3:0]           degree_q;
	logic [MAX_TERMS-1:0] valid_q;
	logic                 rd_vld_q;
	logic [AW-1:0]        k_q;
	logic signed [31:0]   x_q;
	logic signed [31:0]   coef_q;
	logic signed [31:0]   sc_q;
	logic signed [31:0]   acc_p_q;
	logic signed [31:0]   acc_s_q;
	logic signed [31:0]   acc_a_q;
	logic                 ovf_q;
	logic                 done_q;
	result_t              result_q;

	logic                 accept;
	logic                 do_load;
	logic                 idx_ok;
	logic [5:0]           idx_ext;
	logic [5:0]           deg_ext;
	logic [5:0]           lim_ext;
	logic [5:0]           dcl_ext;
	logic [AW-1:0]        dtop;
	logic                 k_top;
	logic                 k_zero;
	logic [AW-1:0]        raddr;
	logic [31:0]          ram_rdata;
	logic signed [31:0]   coef_rd;
	logic                 mul_en;
	logic signed [31:0]   mul_a;
	logic signed [31:0]   mul_b;
	logic signed [63:0]   prod;
	logic                 div_done;
	logic signed [31:0]   quot;
	sat_t                 sat_sc;
	sat_t                 sat_p;
	sat_t                 sat_s;
	sat_t                 sat_a;
	sat_t                 sat_fin;

	// APB register port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_IDX_DEGREE) ? {28'b0, degree_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			degree_q <= '0;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_IDX_DEGREE) begin
			degree_q <= pwdata[3:0];
		end
	end

	// Command decode
	assign busy    = (state_q != S_IDLE);
	assign accept  = start && !busy;
	assign idx_ext = 6'(cmd.coef_index);
	assign idx_ok  = (idx_ext < 6'(MAX_TERMS));
	assign do_load = accept && (cmd.opcode == OP_LOAD) && idx_ok;

	// Degree clamped to the store
	assign deg_ext = 6'(degree_q);
	assign lim_ext = 6'(MAX_TERMS - 1);
	assign dcl_ext = (deg_ext > lim_ext) ? lim_ext : deg_ext;
	assign dtop    = dcl_ext[AW-1:0];
	assign k_top   = (k_q == dtop);
	assign k_zero  = (k_q == '0);

	// Coefficient store; entries never written read as zero
	assign raddr = (state_q == S_IDLE) ? dtop : (k_q - 1'b1);

	pvsa_ram #(
		.WIDTH (DATA_W),
		.DEPTH (MAX_TERMS)
	) u_store (
		.clk   (clk),
		.we    (do_load),
		.waddr (idx_ext[AW-1:0]),
		.wdata (cmd.value),
		.raddr (raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			rd_vld_q <= valid_q[raddr];
			if (do_load) begin
				valid_q[idx_ext[AW-1:0]] <= 1'b1;
			end
		end
	end

	assign coef_rd = rd_vld_q ? ram_rdata : '0;

	// Shared multiplier operand select
	always_comb begin
		mul_en = 1'b0;
		mul_a  = acc_a_q;
		mul_b  = x_q;
		unique case (state_q) inside
			S_LD: begin
				mul_en = 1'b1;
				mul_a  = coef_rd;
				mul_b  = 32'(k_q);
			end
			S_MP: begin
				mul_en = 1'b1;
				mul_a  = acc_p_q;
			end
			S_MS: begin
				mul_en = 1'b1;
				mul_a  = acc_s_q;
			end
			S_MA, S_FIN1: begin
				mul_en = 1'b1;
			end
			default: begin
				mul_en = 1'b0;
			end
		endcase
	end

	pvsa_mul u_mul (
		.clk  (clk),
		.en   (mul_en),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	// Area coefficient a[k] / (k+1)
	pvsa_div #(
		.DVW (DVW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == S_LD),
		.dividend (coef_rd),
		.divisor  (DVW'(k_q) + DVW'(1)),
		.done     (div_done),
		.quotient (quot)
	);

	// Horner step results from the registered product
	assign sat_sc  = sat32(prod);
	assign sat_p   = horner_step(prod, coef_q);
	assign sat_s   = horner_step(prod, sc_q);
	assign sat_a   = horner_step(prod, quot);
	assign sat_fin = horner_step(prod, '0);

	// Sequencer: top coefficient down to zero, then the last area step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			k_q     <= '0;
			ovf_q   <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept && cmd.opcode == OP_EVAL) begin
						k_q     <= dtop;
						ovf_q   <= 1'b0;
						state_q <= S_LD;
					end
				end
				S_LD: begin
					state_q <= S_MP;
				end
				S_MP: begin
					ovf_q   <= ovf_q | sat_sc.ovf;
					state_q <= S_MS;
				end
				S_MS: begin
					if (!k_top) begin
						ovf_q <= ovf_q | sat_p.ovf;
					end
					state_q <= S_MA;
				end
				S_MA: begin
					if (!k_top && !k_zero) begin
						ovf_q <= ovf_q | sat_s.ovf;
					end
					state_q <= S_AREA;
				end
				S_AREA: begin
					if (div_done) begin
						if (!k_top) begin
							ovf_q <= ovf_q | sat_a.ovf;
						end
						if (k_zero) begin
							state_q <= S_FIN1;
						end else begin
							k_q     <= k_q - 1'b1;
							state_q <= S_LD;
						end
					end
				end
				S_FIN1: begin
					state_q <= S_FIN2;
				end
				S_FIN2: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Accumulators and result
	always_ff @(posedge clk) begin
		if (accept && cmd.opcode == OP_EVAL) begin
			x_q <= cmd.value;
		end
		if (state_q == S_LD) begin
			coef_q <= coef_rd;
		end
		if (state_q == S_MP) begin
			sc_q <= sat_sc.val;
		end
		if (state_q == S_MS) begin
			acc_p_q <= k_top ? coef_q : sat_p.val;
		end
		if (state_q == S_MA && !k_zero) begin
			acc_s_q <= k_top ? sc_q : sat_s.val;
		end
		if (state_q == S_AREA && div_done) begin
			acc_a_q <= k_top ? quot : sat_a.val;
		end
		if (state_q == S_FIN2) begin
			result_q.poly_value  <= acc_p_q;
			result_q.slope_value <= (dtop == '0) ? '0 : acc_s_q;
			result_q.area_value  <= sat_fin.val;
			result_q.overflow    <= ovf_q | sat_fin.ovf;
		end
	end

	assign done   = done_q;
	assign result = result_q;

`ifndef SYNTHESIS
	a_done_after_fin: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q) == S_FIN2)
		else $error("result strobe without a finished evaluate");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("busy while a result is shown");

	a_eval_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && cmd.opcode == OP_EVAL) |=> (state_q == S_LD))
		else $error("evaluate accepted but sequencer did not start");

	a_load_single: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && cmd.opcode == OP_LOAD) |=> (!busy && !done))
		else $error("load item left the block busy or made a result");

	a_div_restarted: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MP) |-> !div_done)
		else $error("divider not restarted for this coefficient");
`endif

endmodule

/* src/pvsa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module pvsa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* src/pvsa_mul.sv */
// Shared 32x32 signed multiplier with registered product.
module pvsa_mul (
	input  logic               clk,
	input  logic               en,
	input  logic signed [31:0] a,
	input  logic signed [31:0] b,
	output logic signed [63:0] prod
);

	logic signed [63:0] prod_q;

	// Product holds until the next issue
	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= a * b;
		end
	end

	assign prod = prod_q;

endmodule

/* src/pvsa_div.sv */
// Signed 32-bit by small unsigned divisor, truncating, several quotient bits per cycle.
module pvsa_div #(
	parameter int DVW = 5
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [31:0] dividend,
	input  logic [DVW-1:0]     divisor,
	output logic               done,
	output logic signed [31:0] quotient
);
	import pvsa_pkg::*;

	logic [31:0]          mag_q;
	logic [31:0]          quo_q;
	logic [DVW-1:0]       rem_q;
	logic [DVW-1:0]       dv_q;
	logic                 neg_q;
	logic [DIV_CW-1:0]    cnt_q;
	logic                 run_q;
	logic                 done_q;
	logic [DVW-1:0]       rem_n;
	logic [DVW:0]         rem_w;
	logic [DIV_DIGIT-1:0] quo_bits;

	// Restoring division over one digit of the dividend
	always_comb begin
		rem_n    = rem_q;
		rem_w    = '0;
		quo_bits = '0;
		for (int i = 0; i < DIV_DIGIT; i++) begin
			rem_w = {rem_n, mag_q[DATA_W-1-i]};
			if (rem_w >= {1'b0, dv_q}) begin
				rem_w                     = rem_w - {1'b0, dv_q};
				quo_bits[DIV_DIGIT-1-i] = 1'b1;
			end
			rem_n = rem_w[DVW-1:0];
		end
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (run_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == DIV_CW'(DIV_STEPS - 1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= dividend[31] ? (~dividend + 1'b1) : dividend;
			neg_q <= dividend[31];
			dv_q  <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (run_q) begin
			mag_q <= mag_q << DIV_DIGIT;
			quo_q <= {quo_q[DATA_W-DIV_DIGIT-1:0], quo_bits};
			rem_q <= rem_n;
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? (~quo_q + 1'b1) : quo_q;

endmodule
